// File: hdl/rti_pkg.sv
package rti_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned DIM_W    = 13;
  localparam int unsigned STRIDE_W = 15;
  localparam int unsigned CFG_W    = 15;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned LUMA_W   = 24;
  localparam int unsigned CHROMA_W = 22;

  localparam logic [DIM_W-1:0]    WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0]    HEIGHT_RESET = 13'd480;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 15'd1920;

  localparam logic [DIM_W-1:0] WIDTH_LIMIT  = DIM_W'(MAX_WIDTH & ~1);
  localparam logic [DIM_W-1:0] HEIGHT_LIMIT = DIM_W'(MAX_HEIGHT & ~1);
  localparam logic [DIM_W-1:0] DIM_MIN      = 13'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_ROW_STRIDE   = 3'd2,
    REG_FOUR_BPP     = 3'd3,
    REG_BLUE_FIRST   = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PLANE_Y  = 2'd0,
    PLANE_CB = 2'd1,
    PLANE_CR = 2'd2
  } plane_e;

  typedef struct packed {
    logic                done;
    logic                chroma;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [LUMA_W-1:0]   luma_pos;
    logic [CHROMA_W-1:0] chroma_pos;
  } pix_evt_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] cb;
    logic [7:0] cr;
  } csc_t;

endpackage

// File: hdl/rti_frame_tracker.sv
module rti_frame_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rti_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rti_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                byte_valid_i,
  input  logic [7:0]                          byte_i,
  input  logic                                byte_take_i,
  output rti_pkg::pix_evt_t                   evt_o
);

  logic [rti_pkg::DIM_W-1:0]    width_q, height_q;
  logic [rti_pkg::STRIDE_W-1:0] stride_q;
  logic                         four_q, blue_q;

  logic [rti_pkg::STRIDE_W-1:0] bir_q, bir_d;
  logic [1:0]                   bip_q, bip_d;
  logic [7:0]                   hold1_q, hold1_d, hold2_q, hold2_d;
  logic                         col_q, col_d;
  logic [rti_pkg::DIM_W-1:0]    row_q, row_d;
  logic [rti_pkg::LUMA_W-1:0]   luma_q, luma_d;
  logic [rti_pkg::CHROMA_W-1:0] chroma_q, chroma_d;

  logic [rti_pkg::DIM_W-1:0]    w_even, h_even, w_eff, h_eff;
  logic [rti_pkg::STRIDE_W-1:0] row_bytes, stride_eff;
  logic                         in_row, done, chroma;
  logic [2:0]                   bip_inc, bpp;
  logic [rti_pkg::STRIDE_W:0]   bir_inc;
  logic [rti_pkg::DIM_W-1:0]    row_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rti_pkg::WIDTH_RESET;
      height_q <= rti_pkg::HEIGHT_RESET;
      stride_q <= rti_pkg::STRIDE_RESET;
      four_q   <= 1'b0;
      blue_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rti_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data_i[rti_pkg::DIM_W-1:0];
        rti_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data_i[rti_pkg::DIM_W-1:0];
        rti_pkg::REG_ROW_STRIDE:   stride_q <= cfg_data_i[rti_pkg::STRIDE_W-1:0];
        rti_pkg::REG_FOUR_BPP:     four_q   <= cfg_data_i[0];
        rti_pkg::REG_BLUE_FIRST:   blue_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_even = {width_q[rti_pkg::DIM_W-1:1], 1'b0};
    h_even = {height_q[rti_pkg::DIM_W-1:1], 1'b0};
    if (w_even < rti_pkg::DIM_MIN) begin
      w_eff = rti_pkg::DIM_MIN;
    end else if (w_even > rti_pkg::WIDTH_LIMIT) begin
      w_eff = rti_pkg::WIDTH_LIMIT;
    end else begin
      w_eff = w_even;
    end
    if (h_even < rti_pkg::DIM_MIN) begin
      h_eff = rti_pkg::DIM_MIN;
    end else if (h_even > rti_pkg::HEIGHT_LIMIT) begin
      h_eff = rti_pkg::HEIGHT_LIMIT;
    end else begin
      h_eff = h_even;
    end
    if (four_q) begin
      row_bytes = {w_eff, 2'b00};
      bpp       = 3'd4;
    end else begin
      row_bytes = {2'b00, w_eff} + {1'b0, w_eff, 1'b0};
      bpp       = 3'd3;
    end
    stride_eff = (stride_q < row_bytes) ? row_bytes : stride_q;
    in_row     = bir_q < row_bytes;
    done       = byte_valid_i && in_row && (bip_q == 2'd2);
    chroma     = !row_q[0] && !col_q;
    bip_inc    = {1'b0, bip_q} + 3'd1;
    bir_inc    = {1'b0, bir_q} + 16'd1;
    row_inc    = row_q + 13'd1;

    evt_o.done       = done;
    evt_o.chroma     = chroma;
    evt_o.red        = blue_q ? byte_i : hold1_q;
    evt_o.green      = hold2_q;
    evt_o.blue       = blue_q ? hold1_q : byte_i;
    evt_o.luma_pos   = luma_q;
    evt_o.chroma_pos = chroma_q;
  end

  always_comb begin
    bir_d    = bir_q;
    bip_d    = bip_q;
    hold1_d  = hold1_q;
    hold2_d  = hold2_q;
    col_d    = col_q;
    row_d    = row_q;
    luma_d   = luma_q;
    chroma_d = chroma_q;
    if (byte_take_i) begin
      if (in_row) begin
        case (bip_q)
          2'd0: hold1_d = byte_i;
          2'd1: hold2_d = byte_i;
          2'd2: begin
            if (chroma) begin
              chroma_d = chroma_q + 22'd1;
            end
            luma_d = luma_q + 24'd1;
            col_d  = !col_q;
          end
          default: ;
        endcase
        bip_d = (bip_inc >= bpp) ? 2'd0 : bip_inc[1:0];
      end
      bir_d = bir_inc[rti_pkg::STRIDE_W-1:0];
      if (bir_inc >= {1'b0, stride_eff}) begin
        bir_d = '0;
        bip_d = 2'd0;
        col_d = 1'b0;
        row_d = row_inc;
        if (row_inc >= h_eff) begin
          row_d    = '0;
          luma_d   = '0;
          chroma_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bir_q    <= '0;
      bip_q    <= '0;
      hold1_q  <= '0;
      hold2_q  <= '0;
      col_q    <= 1'b0;
      row_q    <= '0;
      luma_q   <= '0;
      chroma_q <= '0;
    end else begin
      bir_q    <= bir_d;
      bip_q    <= bip_d;
      hold1_q  <= hold1_d;
      hold2_q  <= hold2_d;
      col_q    <= col_d;
      row_q    <= row_d;
      luma_q   <= luma_d;
      chroma_q <= chroma_d;
    end
  end

endmodule

// File: hdl/rti_csc.sv
module rti_csc (
  input  logic [7:0]    red_i,
  input  logic [7:0]    green_i,
  input  logic [7:0]    blue_i,
  output rti_pkg::csc_t csc_o
);

  logic [15:0] y_sum, cb_pos, cb_neg, cb_sum, cr_pos, cr_neg, cr_sum;

  always_comb begin
    y_sum  = 16'd66 * {8'd0, red_i} + 16'd129 * {8'd0, green_i} + 16'd25 * {8'd0, blue_i};
    cb_pos = 16'd56 * {8'd0, blue_i} + 16'd14336;
    cb_neg = 16'd19 * {8'd0, red_i} + 16'd37 * {8'd0, green_i};
    cr_pos = 16'd56 * {8'd0, red_i} + 16'd14336;
    cr_neg = 16'd47 * {8'd0, green_i} + 16'd9 * {8'd0, blue_i};
    cb_sum = cb_pos - cb_neg;
    cr_sum = cr_pos - cr_neg;
    csc_o.y  = y_sum[15:8] + 8'd16;
    csc_o.cb = cb_sum[14:7] + 8'd16;
    csc_o.cr = cr_sum[14:7] + 8'd16;
  end

endmodule

// File: hdl/rti_result_queue.sv
module rti_result_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  rti_pkg::pix_evt_t    evt_i,
  input  rti_pkg::csc_t        csc_i,
  output logic                 free_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,
  output logic [1:0]           m_axis_tuser,
  output logic                 m_axis_tlast
);

  logic                         valid_q, valid_d;
  rti_pkg::plane_e              ptr_q, ptr_d;
  logic                         chroma_q;
  rti_pkg::csc_t                csc_q;
  logic [rti_pkg::LUMA_W-1:0]   luma_q;
  logic [rti_pkg::CHROMA_W-1:0] chroma_pos_q;
  logic                         last, take;
  logic [7:0]                   value;
  logic [rti_pkg::LUMA_W-1:0]   index;

  always_comb begin
    last = chroma_q ? (ptr_q == rti_pkg::PLANE_CR) : 1'b1;
    take = valid_q && m_axis_tready;
    free_o = !valid_q || (m_axis_tready && last);
    case (ptr_q)
      rti_pkg::PLANE_Y:  value = csc_q.y;
      rti_pkg::PLANE_CB: value = csc_q.cb;
      rti_pkg::PLANE_CR: value = csc_q.cr;
      default:           value = csc_q.y;
    endcase
    index = (ptr_q == rti_pkg::PLANE_Y) ? luma_q : {2'b00, chroma_pos_q};
    m_axis_tvalid = valid_q;
    m_axis_tdata  = {value, index};
    m_axis_tuser  = ptr_q;
    m_axis_tlast  = last;

    valid_d = valid_q;
    ptr_d   = ptr_q;
    if (load_i) begin
      valid_d = 1'b1;
      ptr_d   = rti_pkg::PLANE_Y;
    end else if (take) begin
      if (last) begin
        valid_d = 1'b0;
      end else if (ptr_q == rti_pkg::PLANE_Y) begin
        ptr_d = rti_pkg::PLANE_CB;
      end else begin
        ptr_d = rti_pkg::PLANE_CR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ptr_q   <= rti_pkg::PLANE_Y;
    end else begin
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      chroma_q     <= evt_i.chroma;
      csc_q        <= csc_i;
      luma_q       <= evt_i.luma_pos;
      chroma_pos_q <= evt_i.chroma_pos;
    end
  end

endmodule

// File: hdl/rgb_to_i420_converter_unit.sv
// Converts a stream of RGB or BGR source bytes, one byte per request, into I420
// samples: a luma sample for every full pixel, and a Cb and a Cr sample at even
// columns of even rows, each tagged with its plane in tuser and its row-major
// index in the low 24 bits of tdata. A source byte can be taken every cycle; the
// first result of a pixel is loaded into the result register from the input
// register that holds the completing byte. The result register emits one sample
// per cycle while tready is high, so a pixel with chroma occupies it for its Y,
// Cb and Cr samples, and a completing byte waits only while that register is
// still busy; padding and filler bytes never wait on it themselves, though they
// queue behind a completing byte that is waiting. The frame geometry registers
// reset to 640 by 480 pixels with a 1920-byte stride, three bytes per pixel in
// R G B order; the user must write them only while idle, which is not enforced.
module rgb_to_i420_converter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rti_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rti_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] source_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata,  // [23:0] plane_index, [31:24] sample_value
  output logic [1:0]                      m_axis_tuser,  // [1:0] plane_select
  output logic                            m_axis_tlast
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              advance, grp_free;
  rti_pkg::pix_evt_t evt;
  rti_pkg::csc_t     csc;

  assign advance       = in_valid_q && (!evt.done || grp_free);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  rti_frame_tracker u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .byte_valid_i (in_valid_q),
    .byte_i       (in_byte_q),
    .byte_take_i  (advance),
    .evt_o        (evt)
  );

  rti_csc u_csc (
    .red_i   (evt.red),
    .green_i (evt.green),
    .blue_i  (evt.blue),
    .csc_o   (csc)
  );

  rti_result_queue u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance && evt.done),
    .evt_i         (evt),
    .csc_i         (csc),
    .free_o        (grp_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: hdl/rti_checker.sv
module rti_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [31:0]                     m_axis_tdata,
  input logic [1:0]                      m_axis_tuser,
  input logic                            m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("Stalled result changed.");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:24] >= 8'd16 && m_axis_tdata[31:24] <= 8'd239
      && m_axis_tuser != 2'd3)
    else $error("Sample or plane out of range.");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == rti_pkg::PLANE_CB && !m_axis_tlast)
      || (m_axis_tuser == rti_pkg::PLANE_CR && m_axis_tlast)
      || m_axis_tuser == rti_pkg::PLANE_Y)
    else $error("Wrong last flag for chroma sample.");

  a_cr_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser == rti_pkg::PLANE_CB
      |=> m_axis_tvalid && m_axis_tuser == rti_pkg::PLANE_CR
      && m_axis_tdata[23:0] == $past(m_axis_tdata[23:0]))
    else $error("Cr sample did not follow its Cb sample.");

endmodule

bind rgb_to_i420_converter_unit rti_checker u_checker (.*);
